/* design/gfpc_pkg.sv */
// Package: shared constants, codes and item types of the GIF frame pixel compositor.
`timescale 1ns / 1ps

package gfpc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // input item modes
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_PIXEL   = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // key modes
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_BG   = 2'd1;
  localparam logic [1:0] KEY_SKIP = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEFT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLACED       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_INDEX        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_INDEX = 3'd7;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  entry_address;
    logic [23:0] entry_color;
    logic [7:0]  pixel_code;
  } in_item_t;

  typedef struct packed {
    logic [15:0] canvas_x;
    logic [15:0] canvas_y;
    logic [31:0] pixel_word;
    logic        frame_done;
  } out_item_t;

  // frame geometry seen by the position tracker
  typedef struct packed {
    logic [15:0] frame_left;
    logic [15:0] frame_top;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        interlaced;
  } geom_t;

  // position of the current code
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        done;
  } pos_t;

endpackage

/* design/gif_frame_pixel_compositor.sv */
// Top level of the GIF frame pixel compositor: config registers, palette lookup, output stage.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in_       input      in_valid / in_stall   in_item  (mode, address, color, code)
// out_      output     out_valid / out_stall out_item (canvas x, y, ABGR word, done)
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item a cycle while in_stall is low. An accepted pixel code reaches out_valid
// through the lookup stage (palette memory's registered read) and the output register.
// Palette loads, restarts and skipped key codes give no result.
// rst_n clears the counters, valid flags and config registers (width, height to 1);
// the palette stays undefined until loaded, so no clearing pass is needed.
// in_stall rises only when the lookup stage holds a result and out_stall holds the
// output register; an empty slot on either side keeps input flowing.

module gif_frame_pixel_compositor (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gfpc_pkg::in_item_t                  in_item,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output gfpc_pkg::out_item_t                 out_item,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gfpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gfpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  logic [15:0] frame_left_r, frame_top_r, frame_width_r, frame_height_r;
  logic        interlaced_r;
  logic [1:0]  key_mode_r;
  logic [7:0]  key_index_r, background_index_r;

  gfpc_pkg::geom_t geom;
  gfpc_pkg::pos_t  pos;

  // accept side
  logic       in_acc, is_load, is_pixel, is_restart;
  logic       key_hit, use_bg, skip;
  logic [7:0] rd_idx;
  logic       rd_oob, wr_ok;
  logic [23:0] rd_color;

  // lookup stage: waits on the palette read
  logic        s1_v_r;
  logic [15:0] s1_x_r, s1_y_r;
  logic        s1_done_r, s1_oob_r;
  logic        s1_move;

  // output register
  logic                out_v_r;
  gfpc_pkg::out_item_t out_item_r;
  logic [23:0]         color;

  // Config writes are taken at any time; the user writes only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_left_r       <= '0;
      frame_top_r        <= '0;
      frame_width_r      <= 16'd1;
      frame_height_r     <= 16'd1;
      interlaced_r       <= 1'b0;
      key_mode_r         <= gfpc_pkg::KEY_NONE;
      key_index_r        <= '0;
      background_index_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gfpc_pkg::CFG_FRAME_LEFT:       frame_left_r       <= cfg_data;
        gfpc_pkg::CFG_FRAME_TOP:        frame_top_r        <= cfg_data;
        gfpc_pkg::CFG_FRAME_WIDTH:      frame_width_r      <= cfg_data;
        gfpc_pkg::CFG_FRAME_HEIGHT:     frame_height_r     <= cfg_data;
        gfpc_pkg::CFG_INTERLACED:       interlaced_r       <= cfg_data[0];
        gfpc_pkg::CFG_KEY_MODE:         key_mode_r         <= cfg_data[1:0];
        gfpc_pkg::CFG_KEY_INDEX:        key_index_r        <= cfg_data[7:0];
        gfpc_pkg::CFG_BACKGROUND_INDEX: background_index_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign geom.frame_left   = frame_left_r;
  assign geom.frame_top    = frame_top_r;
  assign geom.frame_width  = frame_width_r;
  assign geom.frame_height = frame_height_r;
  assign geom.interlaced   = interlaced_r;

  // Hold input only when the lookup stage is full and cannot drain.
  assign s1_move  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  assign is_load    = in_item.mode == gfpc_pkg::MODE_LOAD;
  assign is_pixel   = in_item.mode == gfpc_pkg::MODE_PIXEL;
  assign is_restart = in_item.mode == gfpc_pkg::MODE_RESTART;

  // Key handling: swap in the background entry or drop the result.
  assign key_hit = in_item.pixel_code == key_index_r;
  assign use_bg  = (key_mode_r == gfpc_pkg::KEY_BG) && key_hit;
  assign skip    = (key_mode_r == gfpc_pkg::KEY_SKIP) && key_hit;
  assign rd_idx  = use_bg ? background_index_r : in_item.pixel_code;

  // Entries past the palette read as black; loads there are dropped.
  assign rd_oob = 32'(rd_idx) >= 32'(gfpc_pkg::PALETTE_ENTRIES);
  assign wr_ok  = 32'(in_item.entry_address) < 32'(gfpc_pkg::PALETTE_ENTRIES);

  // A load and a later read are accepted in different cycles, so the array already
  // holds the new entry when the read is issued.
  gfpc_palette_ram u_palette (
    .clk   (clk),
    .we    (in_acc && is_load && wr_ok),
    .waddr (in_item.entry_address[gfpc_pkg::PAL_AW-1:0]),
    .wdata (in_item.entry_color),
    .re    (in_acc),
    .raddr (rd_idx[gfpc_pkg::PAL_AW-1:0]),
    .rdata (rd_color)
  );

  // Skipped key codes still advance the position.
  gfpc_position u_position (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .advance (in_acc && is_pixel),
    .restart (in_acc && is_restart),
    .pos     (pos)
  );

  // lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= is_pixel && !skip;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r    <= pos.x;
      s1_y_r    <= pos.y;
      s1_done_r <= pos.done;
      s1_oob_r  <= rd_oob;
    end
  end

  // Out-of-palette reads give black; the output stage reorders RGB into the ABGR canvas word.
  assign color = s1_oob_r ? 24'd0 : rd_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item_r.canvas_x   <= s1_x_r;
      out_item_r.canvas_y   <= s1_y_r;
      out_item_r.pixel_word <= {gfpc_pkg::ALPHA_OPAQUE, color[7:0], color[15:8], color[23:16]};
      out_item_r.frame_done <= s1_done_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // Input is held back only behind a full output register.
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && s1_v_r))
    else $error("input held while output register is free");

  // A result leaving the lookup stage lands in the output register.
  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid)
    else $error("lookup result lost");

  // Every delivered word is opaque.
  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.pixel_word[31:24] == gfpc_pkg::ALPHA_OPAQUE))
    else $error("result word without full alpha");

  // A skipped key code never fills the lookup stage.
  a_skip_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_pixel && skip) |=> !s1_v_r)
    else $error("skipped key code produced a result");

endmodule

/* design/gfpc_palette_ram.sv */
// Palette memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module gfpc_palette_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [gfpc_pkg::PAL_AW-1:0] waddr,
  input  logic [23:0]               wdata,
  input  logic                      re,
  input  logic [gfpc_pkg::PAL_AW-1:0] raddr,
  output logic [23:0]               rdata
);

  logic [23:0] mem [gfpc_pkg::PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/gfpc_position.sv */
// Position tracker: column, row and interlace pass counters of the frame rectangle.
`timescale 1ns / 1ps

module gfpc_position (
  input  logic            clk,
  input  logic            rst_n,
  input  gfpc_pkg::geom_t geom,
  input  logic            advance,
  input  logic            restart,
  output gfpc_pkg::pos_t  pos
);

  logic [15:0] col_r, col_nxt;
  logic [15:0] rows_r, rows_nxt;
  logic [15:0] row_r, row_nxt;
  logic [1:0]  pass_r, pass_nxt;

  logic [16:0] w17, h17, col_p1, rows_p1;
  logic        col_end, row_end;
  logic [16:0] il_row;
  logic [1:0]  il_pass;

  function automatic logic [3:0] pass_step(input logic [1:0] p);
    case (p)
      2'd0:    pass_step = 4'd8;
      2'd1:    pass_step = 4'd8;
      2'd2:    pass_step = 4'd4;
      default: pass_step = 4'd2;
    endcase
  endfunction

  function automatic logic [2:0] pass_start(input logic [1:0] p);
    case (p)
      2'd0:    pass_start = 3'd0;
      2'd1:    pass_start = 3'd4;
      2'd2:    pass_start = 3'd2;
      default: pass_start = 3'd1;
    endcase
  endfunction

  assign w17     = {1'b0, (geom.frame_width == 16'd0) ? 16'd1 : geom.frame_width};
  assign h17     = {1'b0, (geom.frame_height == 16'd0) ? 16'd1 : geom.frame_height};
  assign col_p1  = {1'b0, col_r} + 17'd1;
  assign rows_p1 = {1'b0, rows_r} + 17'd1;
  assign col_end = col_p1 >= w17;
  assign row_end = rows_p1 >= h17;

  // interlaced row step; past the height, fall through to later passes
  always_comb begin
    il_row  = {1'b0, row_r} + {13'd0, pass_step(pass_r)};
    il_pass = pass_r;
    for (int i = 0; i < 3; i++) begin
      if (il_row >= h17 && il_pass != 2'd3) begin
        il_pass = il_pass + 2'd1;
        il_row  = {14'd0, pass_start(il_pass)};
      end
    end
  end

  always_comb begin
    col_nxt  = col_r;
    rows_nxt = rows_r;
    row_nxt  = row_r;
    pass_nxt = pass_r;
    if (restart) begin
      col_nxt  = '0;
      rows_nxt = '0;
      row_nxt  = '0;
      pass_nxt = '0;
    end else if (advance) begin
      if (!col_end) begin
        col_nxt = col_p1[15:0];
      end else if (row_end) begin
        col_nxt  = '0;
        rows_nxt = '0;
        row_nxt  = '0;
        pass_nxt = '0;
      end else begin
        col_nxt  = '0;
        rows_nxt = rows_p1[15:0];
        if (geom.interlaced) begin
          row_nxt  = il_row[15:0];
          pass_nxt = il_pass;
        end else begin
          row_nxt = row_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= '0;
      row_r  <= '0;
      pass_r <= '0;
    end else begin
      col_r  <= col_nxt;
      rows_r <= rows_nxt;
      row_r  <= row_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign pos.x    = geom.frame_left + col_r;
  assign pos.y    = geom.frame_top + row_r;
  assign pos.done = col_end && row_end;

endmodule
